>>> hw/rtl/min_heap_priority_queue_defines.svh
// ---------------------------------------------------------------------------
// Min-heap priority queue: assertion macros
// Shared concurrent assertion helpers for the queue RTL.
// ---------------------------------------------------------------------------
`ifndef MIN_HEAP_PRIORITY_QUEUE_DEFINES_SVH
`define MIN_HEAP_PRIORITY_QUEUE_DEFINES_SVH

// Check a property on every rising clock edge outside reset.
`define MHPQ_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Check a property on every rising clock edge, reset included.
`define MHPQ_ASSERT_ALWAYS(name, prop, msg) \
  name: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

>>> hw/rtl/mhpq_pkg.sv
// ---------------------------------------------------------------------------
// mhpq_pkg
// Types and fixed constants of the min-heap priority queue.
// ---------------------------------------------------------------------------
package mhpq_pkg;

  localparam int KEY_W   = 48;
  localparam int ID_W    = 8;
  localparam int WORD_W  = KEY_W + ID_W;
  localparam int REQ_W   = 2;
  localparam int LIMIT_W = 7;
  localparam int HELD_W  = 7;

  // Configuration port
  localparam int APB_DATA_W = 32;
  localparam int APB_ADDR_W = 3;
  localparam logic REG_QUEUE_LIMIT = 1'b0;
  localparam logic [LIMIT_W-1:0] LIMIT_RESET = 7'd64;

  typedef enum logic [REQ_W-1:0] {
    REQ_PUSH = 2'd0,
    REQ_POP  = 2'd1,
    REQ_PEEK = 2'd2
  } req_e;

  typedef struct packed {
    logic [ID_W-1:0]   head_id;
    logic              was_empty;
    logic              push_dropped;
    logic [HELD_W-1:0] entries_held;
  } res_t;

endpackage

>>> hw/rtl/mhpq_store.sv
// ---------------------------------------------------------------------------
// mhpq_store
// Heap word memory: one write port and one read port, registered read data.
// ---------------------------------------------------------------------------
module mhpq_store #(
  parameter int DEPTH = 64
) (
  input  logic                            clk_i,
  input  logic                            rd_en_i,
  input  logic [$clog2(DEPTH)-1:0]        rd_addr_i,
  output logic [mhpq_pkg::WORD_W-1:0]     rd_data_o,
  input  logic                            wr_en_i,
  input  logic [$clog2(DEPTH)-1:0]        wr_addr_i,
  input  logic [mhpq_pkg::WORD_W-1:0]     wr_data_i
);

  logic [mhpq_pkg::WORD_W-1:0] mem [DEPTH];
  logic [mhpq_pkg::WORD_W-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

>>> hw/rtl/mhpq_cfg.sv
// ---------------------------------------------------------------------------
// mhpq_cfg
// APB register slice holding the queue limit.
// ---------------------------------------------------------------------------
module mhpq_cfg (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [mhpq_pkg::APB_ADDR_W-1:0]     paddr,
  input  logic [mhpq_pkg::APB_DATA_W-1:0]     pwdata,
  output logic [mhpq_pkg::APB_DATA_W-1:0]     prdata,
  output logic                                pready,
  output logic [mhpq_pkg::LIMIT_W-1:0]        queue_limit_o
);

  localparam int LimitW = mhpq_pkg::LIMIT_W;
  localparam int DataW  = mhpq_pkg::APB_DATA_W;

  logic [LimitW-1:0] limit_q, limit_d;
  logic              wr_hit;

  assign pready = 1'b1;
  assign wr_hit = psel && penable && pwrite && (paddr[2] == mhpq_pkg::REG_QUEUE_LIMIT);

  always_comb begin
    limit_d = limit_q;
    if (wr_hit) begin
      limit_d = pwdata[LimitW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q <= mhpq_pkg::LIMIT_RESET;
    end else begin
      limit_q <= limit_d;
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr[2] == mhpq_pkg::REG_QUEUE_LIMIT) begin
      prdata = DataW'(limit_q);
    end
  end

  assign queue_limit_o = limit_q;

endmodule

>>> hw/rtl/mhpq_ctrl.sv
// ---------------------------------------------------------------------------
// mhpq_ctrl
// Request sequencer: push with sift-up, pop with sift-down, peek, one
// memory read and one compare per step.
// ---------------------------------------------------------------------------
`include "min_heap_priority_queue_defines.svh"

module mhpq_ctrl #(
  parameter int DEPTH = 64
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic [mhpq_pkg::LIMIT_W-1:0]      queue_limit_i,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic [mhpq_pkg::REQ_W-1:0]        req_type_i,
  input  logic [mhpq_pkg::ID_W-1:0]         entry_id_i,
  input  logic [mhpq_pkg::KEY_W-1:0]        entry_key_i,
  input  logic                              out_free_i,
  output logic                              res_valid_o,
  output mhpq_pkg::res_t                    res_o,
  output logic                              rd_en_o,
  output logic [$clog2(DEPTH)-1:0]          rd_addr_o,
  input  logic [mhpq_pkg::WORD_W-1:0]       rd_data_i,
  output logic                              wr_en_o,
  output logic [$clog2(DEPTH)-1:0]          wr_addr_o,
  output logic [mhpq_pkg::WORD_W-1:0]       wr_data_o
);

  localparam int AW     = $clog2(DEPTH);
  localparam int CNT_W  = $clog2(DEPTH + 1);
  localparam int CHW    = AW + 2;
  localparam int LIM_W  = (CNT_W > mhpq_pkg::LIMIT_W) ? CNT_W : mhpq_pkg::LIMIT_W;
  localparam int WordW  = mhpq_pkg::WORD_W;
  localparam int IdW    = mhpq_pkg::ID_W;
  localparam int HeldW  = mhpq_pkg::HELD_W;

  typedef enum logic [8:0] {
    ST_IDLE   = 9'b000000001,
    ST_HEAD   = 9'b000000010,
    ST_LAST   = 9'b000000100,
    ST_DN_CHK = 9'b000001000,
    ST_DN_L   = 9'b000010000,
    ST_DN_R   = 9'b000100000,
    ST_UP_CHK = 9'b001000000,
    ST_UP_CMP = 9'b010000000,
    ST_POST   = 9'b100000000
  } state_e;

  state_e              state_q, state_d;
  mhpq_pkg::req_e      req_q, req_d;
  logic [CNT_W-1:0]    count_q, count_d;
  logic [AW-1:0]       pos_q, pos_d;
  logic [WordW-1:0]    elem_q, elem_d;
  logic [WordW-1:0]    min_q, min_d;
  logic                lsel_q, lsel_d;
  logic [IdW-1:0]      head_q, head_d;
  logic                empty_q, empty_d;
  logic                drop_q, drop_d;

  logic                accept;
  logic                full;
  logic [LIM_W-1:0]    lim_cfg, lim_dep, lim_eff;
  logic [CHW-1:0]      left_w, right_w, count_w;
  logic [AW-1:0]       parent;
  logic                left_lt;
  logic                elem_lt;

  assign accept     = in_valid_i && (state_q == ST_IDLE);
  assign in_stall_o = (state_q != ST_IDLE);

  // Effective limit is the configured one, capped at the memory depth
  assign lim_cfg = LIM_W'(queue_limit_i);
  assign lim_dep = LIM_W'(DEPTH);
  assign lim_eff = (lim_cfg > lim_dep) ? lim_dep : lim_cfg;
  assign full    = (LIM_W'(count_q) >= lim_eff);

  assign left_w  = {1'b0, pos_q, 1'b1};
  assign right_w = left_w + CHW'(1);
  assign count_w = CHW'(count_q);
  assign parent  = (pos_q - AW'(1)) >> 1;
  assign left_lt = (rd_data_i < elem_q);
  assign elem_lt = (elem_q < rd_data_i);

  always_comb begin
    state_d   = state_q;
    req_d     = req_q;
    count_d   = count_q;
    pos_d     = pos_q;
    elem_d    = elem_q;
    min_d     = min_q;
    lsel_d    = lsel_q;
    head_d    = head_q;
    empty_d   = empty_q;
    drop_d    = drop_q;
    rd_en_o   = 1'b0;
    rd_addr_o = '0;
    wr_en_o   = 1'b0;
    wr_addr_o = pos_q;
    wr_data_o = elem_q;

    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          req_d   = mhpq_pkg::req_e'(req_type_i);
          head_d  = '0;
          empty_d = 1'b0;
          drop_d  = 1'b0;
          unique case (mhpq_pkg::req_e'(req_type_i))
            mhpq_pkg::REQ_PUSH: begin
              if (full) begin
                drop_d  = 1'b1;
                state_d = ST_POST;
              end else begin
                elem_d  = {entry_key_i, entry_id_i};
                pos_d   = AW'(count_q);
                count_d = count_q + CNT_W'(1);
                state_d = ST_UP_CHK;
              end
            end
            mhpq_pkg::REQ_POP, mhpq_pkg::REQ_PEEK: begin
              if (count_q == '0) begin
                empty_d = 1'b1;
                state_d = ST_POST;
              end else begin
                rd_en_o   = 1'b1;
                rd_addr_o = '0;
                state_d   = ST_HEAD;
              end
            end
            default: begin
              state_d = ST_POST;
            end
          endcase
        end
      end

      ST_HEAD: begin
        head_d = rd_data_i[IdW-1:0];
        if (req_q == mhpq_pkg::REQ_POP) begin
          count_d = count_q - CNT_W'(1);
          if (count_q == CNT_W'(1)) begin
            state_d = ST_POST;
          end else begin
            // fetch the last entry to refill the root
            rd_en_o   = 1'b1;
            rd_addr_o = AW'(count_q - CNT_W'(1));
            state_d   = ST_LAST;
          end
        end else begin
          state_d = ST_POST;
        end
      end

      ST_LAST: begin
        elem_d  = rd_data_i;
        pos_d   = '0;
        state_d = ST_DN_CHK;
      end

      ST_DN_CHK: begin
        if (left_w >= count_w) begin
          wr_en_o = 1'b1;
          state_d = ST_POST;
        end else begin
          rd_en_o   = 1'b1;
          rd_addr_o = left_w[AW-1:0];
          state_d   = ST_DN_L;
        end
      end

      ST_DN_L: begin
        lsel_d = left_lt;
        min_d  = left_lt ? rd_data_i : elem_q;
        if (right_w < count_w) begin
          rd_en_o   = 1'b1;
          rd_addr_o = right_w[AW-1:0];
          state_d   = ST_DN_R;
        end else if (left_lt) begin
          wr_en_o   = 1'b1;
          wr_data_o = rd_data_i;
          pos_d     = left_w[AW-1:0];
          state_d   = ST_DN_CHK;
        end else begin
          wr_en_o = 1'b1;
          state_d = ST_POST;
        end
      end

      ST_DN_R: begin
        if (rd_data_i < min_q) begin
          wr_en_o   = 1'b1;
          wr_data_o = rd_data_i;
          pos_d     = right_w[AW-1:0];
          state_d   = ST_DN_CHK;
        end else if (lsel_q) begin
          wr_en_o   = 1'b1;
          wr_data_o = min_q;
          pos_d     = left_w[AW-1:0];
          state_d   = ST_DN_CHK;
        end else begin
          wr_en_o = 1'b1;
          state_d = ST_POST;
        end
      end

      ST_UP_CHK: begin
        if (pos_q == '0) begin
          wr_en_o = 1'b1;
          state_d = ST_POST;
        end else begin
          rd_en_o   = 1'b1;
          rd_addr_o = parent;
          state_d   = ST_UP_CMP;
        end
      end

      ST_UP_CMP: begin
        if (elem_lt) begin
          // move the parent down into the hole
          wr_en_o   = 1'b1;
          wr_data_o = rd_data_i;
          pos_d     = parent;
          state_d   = ST_UP_CHK;
        end else begin
          wr_en_o = 1'b1;
          state_d = ST_POST;
        end
      end

      ST_POST: begin
        if (out_free_i) begin
          state_d = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  assign res_valid_o        = (state_q == ST_POST) && out_free_i;
  assign res_o.head_id      = head_q;
  assign res_o.was_empty    = empty_q;
  assign res_o.push_dropped = drop_q;
  assign res_o.entries_held = HeldW'(count_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      count_q <= '0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    req_q   <= req_d;
    pos_q   <= pos_d;
    elem_q  <= elem_d;
    min_q   <= min_d;
    lsel_q  <= lsel_d;
    head_q  <= head_d;
    empty_q <= empty_d;
    drop_q  <= drop_d;
  end

  `MHPQ_ASSERT(a_count_bound, count_q <= DEPTH, "entry count exceeds heap depth")
  `MHPQ_ASSERT(a_write_in_heap, wr_en_o |-> (wr_addr_o < count_q), "heap write beyond entry count")
  `MHPQ_ASSERT(a_pop_shrinks, (state_q == ST_HEAD && req_q == mhpq_pkg::REQ_POP) |=> (count_q == $past(count_q) - CNT_W'(1)), "pop did not remove one entry")

endmodule

>>> hw/rtl/min_heap_priority_queue.sv
// ---------------------------------------------------------------------------
// min_heap_priority_queue
// Bounded binary min-heap priority queue with push, pop and peek requests.
// ---------------------------------------------------------------------------
//  Channel | Direction | Handshake            | Payload
//  --------+-----------+----------------------+------------------------------------
//  in      | input     | in_valid_i/in_stall_o | req_type_i, entry_id_i, entry_key_i
//  out     | output    | out_valid_o/out_stall_i | head_id_o, was_empty_o,
//          |           |                      | push_dropped_o, entries_held_o
//  cfg     | input     | APB psel/penable     | queue_limit at byte address 0
//
//  One transaction in flight. Push sifts up and pop sifts down through up to
//  log2(DEPTH) levels. Each sift-up level costs one read of the single-read-port
//  heap memory plus a compare; each sift-down level reads the left child and,
//  if present, the right child, with a compare after each read.
//  Reset clears the entry count and sets queue_limit to 64; the heap memory
//  is not cleared. A finished result waits in the output register while the
//  next transaction is accepted; a second result waits until it is taken.
// ---------------------------------------------------------------------------
module min_heap_priority_queue #(
  parameter int DEPTH = 64
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  output logic                             in_stall_o,
  input  logic [mhpq_pkg::REQ_W-1:0]       req_type_i,
  input  logic [mhpq_pkg::ID_W-1:0]        entry_id_i,
  input  logic [mhpq_pkg::KEY_W-1:0]       entry_key_i,
  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output logic [mhpq_pkg::ID_W-1:0]        head_id_o,
  output logic                             was_empty_o,
  output logic                             push_dropped_o,
  output logic [mhpq_pkg::HELD_W-1:0]      entries_held_o,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [mhpq_pkg::APB_ADDR_W-1:0]  paddr,
  input  logic [mhpq_pkg::APB_DATA_W-1:0]  pwdata,
  output logic [mhpq_pkg::APB_DATA_W-1:0]  prdata,
  output logic                             pready
);

  localparam int AW = $clog2(DEPTH);

  logic [mhpq_pkg::LIMIT_W-1:0] queue_limit;
  logic                         rd_en, wr_en;
  logic [AW-1:0]                rd_addr, wr_addr;
  logic [mhpq_pkg::WORD_W-1:0]  rd_data, wr_data;
  logic                         out_free, res_valid;
  mhpq_pkg::res_t               res;
  mhpq_pkg::res_t               out_q;
  logic                         out_valid_q, out_valid_d;

  mhpq_cfg u_cfg (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready),
    .queue_limit_o (queue_limit)
  );

  mhpq_store #(
    .DEPTH (DEPTH)
  ) u_store (
    .clk_i     (clk_i),
    .rd_en_i   (rd_en),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_data),
    .wr_en_i   (wr_en),
    .wr_addr_i (wr_addr),
    .wr_data_i (wr_data)
  );

  mhpq_ctrl #(
    .DEPTH (DEPTH)
  ) u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .queue_limit_i (queue_limit),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .req_type_i    (req_type_i),
    .entry_id_i    (entry_id_i),
    .entry_key_i   (entry_key_i),
    .out_free_i    (out_free),
    .res_valid_o   (res_valid),
    .res_o         (res),
    .rd_en_o       (rd_en),
    .rd_addr_o     (rd_addr),
    .rd_data_i     (rd_data),
    .wr_en_o       (wr_en),
    .wr_addr_o     (wr_addr),
    .wr_data_o     (wr_data)
  );

  // Output register is free when it is empty or when its result is taken in the same cycle
  assign out_free = !out_valid_q || !out_stall_i;

  always_comb begin
    out_valid_d = out_valid_q;
    if (res_valid) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid) begin
      out_q <= res;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign head_id_o      = out_q.head_id;
  assign was_empty_o    = out_q.was_empty;
  assign push_dropped_o = out_q.push_dropped;
  assign entries_held_o = out_q.entries_held;

endmodule

>>> tb/min_heap_priority_queue_tb.sv
// ---------------------------------------------------------------------------
// min_heap_priority_queue_tb
// Self-checking bench for the bounded min-heap queue. A clocked driver feeds
// push, pop, peek and unused requests from a queue of pending items. A clocked
// monitor compares every reply with a prediction from a behavioral copy of the
// heap contents. Phases run under different queue limits set over APB, with
// random gaps on both channels and one long receiver hold-off.
// ---------------------------------------------------------------------------
module min_heap_priority_queue_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int DEPTH            = 64;
  localparam int MAX_REPORTS      = 10;
  localparam int SETTLE_CYCLES    = 32;
  localparam int LONG_HOLD_CYCLES = 400;
  localparam int WATCHDOG_LIMIT   = 4000;
  localparam int RUN_CYCLE_LIMIT  = 1000000;

  localparam logic [mhpq_pkg::REQ_W-1:0]      REQ_NOP       = 2'd3;
  localparam logic [mhpq_pkg::APB_ADDR_W-1:0] LIMIT_ADDR    =
    mhpq_pkg::APB_ADDR_W'(4 * mhpq_pkg::REG_QUEUE_LIMIT);
  localparam logic [mhpq_pkg::APB_ADDR_W-1:0] UNMAPPED_ADDR =
    mhpq_pkg::APB_ADDR_W'(4 * (mhpq_pkg::REG_QUEUE_LIMIT + 1));
  localparam logic [mhpq_pkg::KEY_W-1:0]      KEY_MAX       = {mhpq_pkg::KEY_W{1'b1}};

  typedef struct packed {
    logic [mhpq_pkg::REQ_W-1:0] req;
    logic [mhpq_pkg::ID_W-1:0]  id;
    logic [mhpq_pkg::KEY_W-1:0] key;
  } heap_request_t;

  typedef enum {MIX_FILL, MIX_DRAIN, MIX_EVEN} mix_e;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  logic                        in_valid_i = 1'b0;
  logic                        in_stall_o;
  logic [mhpq_pkg::REQ_W-1:0]  req_type_i = '0;
  logic [mhpq_pkg::ID_W-1:0]   entry_id_i = '0;
  logic [mhpq_pkg::KEY_W-1:0]  entry_key_i = '0;
  logic                        out_valid_o;
  logic                        out_stall_i = 1'b0;
  logic [mhpq_pkg::ID_W-1:0]   head_id_o;
  logic                        was_empty_o;
  logic                        push_dropped_o;
  logic [mhpq_pkg::HELD_W-1:0] entries_held_o;

  logic                            psel = 1'b0;
  logic                            penable = 1'b0;
  logic                            pwrite = 1'b0;
  logic [mhpq_pkg::APB_ADDR_W-1:0] paddr = '0;
  logic [mhpq_pkg::APB_DATA_W-1:0] pwdata = '0;
  logic [mhpq_pkg::APB_DATA_W-1:0] prdata;
  logic                            pready;

  // Behavioral copy of the queue: unordered {key, id} words
  logic [mhpq_pkg::WORD_W-1:0]  held_words[$];
  logic [mhpq_pkg::LIMIT_W-1:0] model_limit = mhpq_pkg::LIMIT_RESET;

  heap_request_t  requests_pending[$];
  mhpq_pkg::res_t expected_replies[$];
  heap_request_t  offered_request;
  mhpq_pkg::res_t reply_seen;

  int unsigned send_gap_max = 0;
  int unsigned reply_stall_max = 0;
  int unsigned send_wait;
  int unsigned stall_left;
  int unsigned reply_pause;
  int unsigned hold_off_req = 0;
  int unsigned hold_off_taken;
  int unsigned hold_off_left;
  int unsigned mismatch_count = 0;
  int unsigned idle_cycles = 0;
  int unsigned run_cycles = 0;

  assign reply_seen = {head_id_o, was_empty_o, push_dropped_o, entries_held_o};

  min_heap_priority_queue #(
    .DEPTH(DEPTH)
  ) dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .req_type_i    (req_type_i),
    .entry_id_i    (entry_id_i),
    .entry_key_i   (entry_key_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .head_id_o     (head_id_o),
    .was_empty_o   (was_empty_o),
    .push_dropped_o(push_dropped_o),
    .entries_held_o(entries_held_o),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // Apply one request to the queue copy and return the reply it produces
  function automatic mhpq_pkg::res_t predict_heap_request(input heap_request_t rq);
    mhpq_pkg::res_t reply;
    int unsigned    cap;
    int             least;
    reply = '0;
    cap = (model_limit > DEPTH) ? DEPTH : model_limit;
    case (rq.req)
      mhpq_pkg::REQ_PUSH: begin
        if (held_words.size() >= cap) begin
          reply.push_dropped = 1'b1;
        end else begin
          held_words.push_back({rq.key, rq.id});
        end
      end
      mhpq_pkg::REQ_POP, mhpq_pkg::REQ_PEEK: begin
        if (held_words.size() == 0) begin
          reply.was_empty = 1'b1;
        end else begin
          least = 0;
          for (int i = 1; i < held_words.size(); i++) begin
            if (held_words[i] < held_words[least]) least = i;
          end
          reply.head_id = held_words[least][mhpq_pkg::ID_W-1:0];
          if (rq.req == mhpq_pkg::REQ_POP) held_words.delete(least);
        end
      end
      default: ;
    endcase
    reply.entries_held = mhpq_pkg::HELD_W'(held_words.size());
    return reply;
  endfunction

  function automatic void note_mismatch(input string what, input mhpq_pkg::res_t want,
                                        input mhpq_pkg::res_t got);
    mismatch_count++;
    if (mismatch_count <= MAX_REPORTS) begin
      $display("%0t: %s: expected id=%0d empty=%0b dropped=%0b held=%0d,",
               $time, what, want.head_id, want.was_empty, want.push_dropped,
               want.entries_held);
      $display("    got id=%0d empty=%0b dropped=%0b held=%0d",
               got.head_id, got.was_empty, got.push_dropped, got.entries_held);
    end
  endfunction

  function automatic heap_request_t random_request(input mix_e mix);
    heap_request_t rq;
    int unsigned   roll;
    int unsigned   push_pct;
    int unsigned   pop_pct;
    case (mix)
      MIX_FILL: begin
        push_pct = 70;
        pop_pct  = 15;
      end
      MIX_DRAIN: begin
        push_pct = 20;
        pop_pct  = 65;
      end
      default: begin
        push_pct = 45;
        pop_pct  = 40;
      end
    endcase
    roll = $urandom_range(0, 99);
    if (roll < push_pct) rq.req = mhpq_pkg::REQ_PUSH;
    else if (roll < push_pct + pop_pct) rq.req = mhpq_pkg::REQ_POP;
    else if (roll < 96) rq.req = mhpq_pkg::REQ_PEEK;
    else rq.req = REQ_NOP;
    // Small keys and ids make ties common; wide ones toggle every bit
    roll = $urandom_range(0, 99);
    if (roll < 45) rq.key = mhpq_pkg::KEY_W'($urandom_range(0, 15));
    else if (roll < 65) rq.key = mhpq_pkg::KEY_W'($urandom_range(0, 1000));
    else if (roll < 90) rq.key = mhpq_pkg::KEY_W'({$urandom(), $urandom()});
    else rq.key = ($urandom_range(0, 1) != 0) ? KEY_MAX : '0;
    rq.id = ($urandom_range(0, 1) != 0) ? mhpq_pkg::ID_W'($urandom()) :
                                          mhpq_pkg::ID_W'($urandom_range(0, 3));
    return rq;
  endfunction

  // Driver: present pending requests, hold while stalled, idle between them
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      send_wait  <= 0;
    end else begin
      if (in_valid_i && !in_stall_o) begin
        expected_replies.push_back(predict_heap_request(offered_request));
      end
      if (in_valid_i && in_stall_o) begin
        in_valid_i <= 1'b1;
      end else if (send_wait != 0) begin
        send_wait  <= send_wait - 1;
        in_valid_i <= 1'b0;
      end else if (requests_pending.size() != 0) begin
        offered_request = requests_pending.pop_front();
        req_type_i  <= offered_request.req;
        entry_id_i  <= offered_request.id;
        entry_key_i <= offered_request.key;
        in_valid_i  <= 1'b1;
        send_wait   <= $urandom_range(0, send_gap_max);
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // Receiver: random stall after each reply, plus a long hold-off on request
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall_i    <= 1'b0;
      stall_left     <= 0;
      hold_off_left  <= 0;
      hold_off_taken <= 0;
    end else if (hold_off_left != 0) begin
      hold_off_left <= hold_off_left - 1;
      out_stall_i   <= (hold_off_left > 1);
    end else if (hold_off_req != hold_off_taken) begin
      hold_off_taken <= hold_off_req;
      hold_off_left  <= LONG_HOLD_CYCLES;
      out_stall_i    <= 1'b1;
    end else if (out_valid_o && !out_stall_i) begin
      reply_pause = $urandom_range(0, reply_stall_max);
      stall_left  <= reply_pause;
      out_stall_i <= (reply_pause != 0);
    end else if (stall_left != 0) begin
      stall_left  <= stall_left - 1;
      out_stall_i <= (stall_left > 1);
    end else begin
      out_stall_i <= 1'b0;
    end
  end

  // Monitor: check each reply against the oldest prediction
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_replies.size() == 0) begin
        note_mismatch("reply with no request outstanding", '0, reply_seen);
      end else if (reply_seen.head_id !== expected_replies[0].head_id ||
                   reply_seen.was_empty !== expected_replies[0].was_empty ||
                   reply_seen.push_dropped !== expected_replies[0].push_dropped ||
                   reply_seen.entries_held !== expected_replies[0].entries_held) begin
        note_mismatch("reply mismatch", expected_replies.pop_front(), reply_seen);
      end else begin
        void'(expected_replies.pop_front());
      end
    end
  end

  always @(posedge clk_i) begin
    run_cycles <= run_cycles + 1;
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= WATCHDOG_LIMIT || run_cycles >= RUN_CYCLE_LIMIT) begin
      $display("%0t: timeout, %0d replies outstanding", $time, expected_replies.size());
      $display("** min_heap_priority_queue: FAILED **");
      $finish;
    end
  end

  task automatic apb_write(input logic [mhpq_pkg::APB_ADDR_W-1:0] addr,
                           input logic [mhpq_pkg::APB_DATA_W-1:0] data);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (addr == LIMIT_ADDR) model_limit = data[mhpq_pkg::LIMIT_W-1:0];
  endtask

  task automatic check_limit_readback();
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= LIMIT_ADDR;
    @(posedge clk_i);
    penable <= 1'b1;
    @(negedge clk_i);
    if (prdata !== mhpq_pkg::APB_DATA_W'(model_limit)) begin
      mismatch_count++;
      if (mismatch_count <= MAX_REPORTS) begin
        $display("%0t: queue_limit readback: expected %0d, got %0d", $time, model_limit, prdata);
      end
    end
    @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // Wait until every request is sent and every reply has come back
  task automatic wait_idle();
    do @(negedge clk_i);
    while (requests_pending.size() != 0 || in_valid_i || expected_replies.size() != 0);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  task automatic queue_request(input logic [mhpq_pkg::REQ_W-1:0] req,
                               input logic [mhpq_pkg::ID_W-1:0] id,
                               input logic [mhpq_pkg::KEY_W-1:0] key);
    heap_request_t rq;
    rq.req = req;
    rq.id  = id;
    rq.key = key;
    requests_pending.push_back(rq);
  endtask

  task automatic run_phase(input int unsigned limit, input mix_e mix, input int unsigned count,
                           input int unsigned send_max, input int unsigned reply_max,
                           input bit long_hold);
    wait_idle();
    apb_write(LIMIT_ADDR, mhpq_pkg::APB_DATA_W'(limit));
    check_limit_readback();
    @(negedge clk_i);
    send_gap_max    = send_max;
    reply_stall_max = reply_max;
    if (long_hold) hold_off_req++;
    repeat (count) requests_pending.push_back(random_request(mix));
  endtask

  initial begin
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    check_limit_readback();
    @(negedge clk_i);
    send_gap_max    = 3;
    reply_stall_max = 3;

    // Empty queue, extreme keys and ids, ties on key and on the whole entry
    queue_request(mhpq_pkg::REQ_PEEK, 8'h00, '0);
    queue_request(mhpq_pkg::REQ_POP, 8'hFF, KEY_MAX);
    queue_request(REQ_NOP, 8'hFF, KEY_MAX);
    queue_request(mhpq_pkg::REQ_PUSH, 8'hFF, KEY_MAX);
    queue_request(mhpq_pkg::REQ_PUSH, 8'h00, '0);
    queue_request(mhpq_pkg::REQ_PUSH, 8'hFF, '0);
    queue_request(mhpq_pkg::REQ_PEEK, 8'h5A, 48'hA5A5_A5A5_A5A5);
    queue_request(mhpq_pkg::REQ_PUSH, 8'h00, '0);
    queue_request(mhpq_pkg::REQ_PUSH, 8'h80, 48'h8000_0000_0000);
    queue_request(mhpq_pkg::REQ_PUSH, 8'h01, 48'h0000_0000_0001);
    queue_request(REQ_NOP, 8'h55, 48'h5555_5555_5555);
    queue_request(mhpq_pkg::REQ_POP, 8'h00, '0);
    queue_request(mhpq_pkg::REQ_POP, 8'h00, '0);
    queue_request(mhpq_pkg::REQ_PEEK, 8'h00, '0);
    queue_request(mhpq_pkg::REQ_POP, 8'h00, '0);
    queue_request(mhpq_pkg::REQ_PUSH, 8'h7F, 48'h7FFF_FFFF_FFFF);
    queue_request(mhpq_pkg::REQ_PUSH, 8'h02, 48'h0000_0000_0001);
    queue_request(mhpq_pkg::REQ_POP, 8'h00, '0);
    queue_request(mhpq_pkg::REQ_POP, 8'h00, '0);
    queue_request(mhpq_pkg::REQ_POP, 8'h00, '0);
    queue_request(mhpq_pkg::REQ_POP, 8'h00, '0);
    queue_request(mhpq_pkg::REQ_PEEK, 8'h00, '0);
    queue_request(mhpq_pkg::REQ_POP, 8'h00, '0);
    queue_request(mhpq_pkg::REQ_POP, 8'h00, '0);
    queue_request(mhpq_pkg::REQ_PEEK, 8'h00, '0);

    run_phase(1, MIX_EVEN, 40, 5, 5, 1'b0);
    run_phase(0, MIX_FILL, 30, 2, 2, 1'b0);
    run_phase(127, MIX_FILL, 150, 5, 5, 1'b0);
    run_phase(64, MIX_DRAIN, 100, 0, 0, 1'b0);
    run_phase(64, MIX_FILL, 100, 5, 5, 1'b0);
    // Limit drops below the current count: pushes refused until pops catch up
    run_phase(10, MIX_EVEN, 120, 3, 5, 1'b0);

    // A write outside the register map must leave the limit alone
    wait_idle();
    apb_write(UNMAPPED_ADDR, 32'h0000_0005);
    check_limit_readback();

    // Flood the input while the receiver holds off
    run_phase(64, MIX_FILL, 150, 0, 0, 1'b1);
    run_phase(100, MIX_EVEN, 150, 5, 0, 1'b0);
    run_phase(33, MIX_FILL, 100, 5, 5, 1'b0);
    run_phase($urandom_range(1, 127), MIX_EVEN, 120, 4, 4, 1'b0);
    run_phase(64, MIX_DRAIN, 150, 5, 5, 1'b0);
    run_phase(2, MIX_EVEN, 60, 1, 3, 1'b0);

    wait_idle();
    if (mismatch_count == 0 && expected_replies.size() == 0) begin
      $display("** min_heap_priority_queue: PASSED **");
    end else begin
      $display("** min_heap_priority_queue: FAILED **");
    end
    $finish;
  end

endmodule
